/* design/bilinear_image_scaler_assert.svh */
// Assertion macros for the bilinear image scaler checker.
// No dependencies; included by the checker file.
`ifndef BILINEAR_IMAGE_SCALER_ASSERT_SVH
`define BILINEAR_IMAGE_SCALER_ASSERT_SVH
// Same-cycle implication, disabled in reset.
`define BIS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled in reset.
`define BIS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
// Next-cycle implication that also holds across reset.
`define BIS_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);
`endif

/* design/bis_pkg.sv */
// Shared constants, types and helpers of the bilinear image scaler.
// No dependencies; imported by every module of the block except bis_ram.
package bis_pkg;

  localparam int MAX_IN_DIM   = 256;
  localparam int MAX_OUT_DIM  = 4096;
  localparam int FRAC_BITS    = 16;

  localparam int IN_BITS      = $clog2(MAX_IN_DIM);
  localparam int IN_DIM_BITS  = $clog2(MAX_IN_DIM + 1);
  localparam int OUT_DIM_BITS = $clog2(MAX_OUT_DIM + 1);
  localparam int ADDR_BITS    = 2 * IN_BITS;
  localparam int STORE_DEPTH  = MAX_IN_DIM * MAX_IN_DIM;

  localparam int COORD_BITS   = 12;
  localparam int CHAN_BITS    = 8;
  localparam int NUM_CHAN     = 4;
  localparam int PIX_BITS     = NUM_CHAN * CHAN_BITS;
  localparam int CFG_IN_BITS  = 9;
  localparam int CFG_OUT_BITS = 13;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 13;

  localparam int QUOT_BITS    = IN_BITS + FRAC_BITS;
  localparam int REM_BITS     = OUT_DIM_BITS + IN_BITS + 1;
  localparam int WGT_BITS     = FRAC_BITS + 1;
  localparam int TOP_BITS     = CHAN_BITS + FRAC_BITS + 1;
  localparam int ACC_BITS     = TOP_BITS + WGT_BITS + 1;

  localparam int QUEUE_DEPTH  = 4;
  localparam int OUT_DEPTH    = 4;

  localparam logic [CHAN_BITS-1:0] CHAN_MAX = 8'hFF;
  localparam logic [WGT_BITS-1:0]  ONE      = WGT_BITS'(1) << FRAC_BITS;

  localparam logic       OP_LOAD    = 1'b0;
  localparam logic       OP_COMPUTE = 1'b1;
  localparam logic [1:0] MODE_RGBA  = 2'd0;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_IN_WIDTH, REG_IN_HEIGHT, REG_OUT_WIDTH, REG_OUT_HEIGHT, REG_MODE
  } reg_idx_t;

  typedef enum logic [1:0] {BK_IDLE, BK_RD1, BK_RD2, BK_RD3} bk_state_t;

  // Clamped, decoded configuration
  typedef struct packed {
    logic [IN_DIM_BITS-1:0]  iw;
    logic [IN_DIM_BITS-1:0]  ih;
    logic [OUT_DIM_BITS-1:0] ow;
    logic [OUT_DIM_BITS-1:0] oh;
    logic                    nearest;
    logic                    alpha_force;
  } cfg_t;

  // Classified command from front to back
  typedef struct packed {
    logic                 is_load;
    logic                 alpha_force;
    logic [IN_BITS-1:0]   x1;
    logic [IN_BITS-1:0]   x2;
    logic [IN_BITS-1:0]   y1;
    logic [IN_BITS-1:0]   y2;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;
    logic [PIX_BITS-1:0]  pixel;
  } cmd_t;

  function automatic logic [IN_DIM_BITS-1:0] clamp_in(input logic [CFG_IN_BITS-1:0] v);
    logic [IN_DIM_BITS-1:0] r;
    if (v == '0) r = IN_DIM_BITS'(1);
    else if (int'(v) > MAX_IN_DIM) r = IN_DIM_BITS'(MAX_IN_DIM);
    else r = IN_DIM_BITS'(v);
    return r;
  endfunction

  function automatic logic [OUT_DIM_BITS-1:0] clamp_out(input logic [CFG_OUT_BITS-1:0] v);
    logic [OUT_DIM_BITS-1:0] r;
    if (v == '0) r = OUT_DIM_BITS'(1);
    else if (int'(v) > MAX_OUT_DIM) r = OUT_DIM_BITS'(MAX_OUT_DIM);
    else r = OUT_DIM_BITS'(v);
    return r;
  endfunction

endpackage

/* design/bis_ram.sv */
// Generic single-port RAM with registered read.
// No dependencies.
module bis_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

/* design/bis_front.sv */
// Front end: accepts items, drops out-of-range loads, maps output coordinates
// to source positions through a one-bit-per-stage divider. Uses bis_pkg.
module bis_front import bis_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  cfg_t                  cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_op,
  input  logic [COORD_BITS-1:0] in_col,
  input  logic [COORD_BITS-1:0] in_row,
  input  logic [PIX_BITS-1:0]   in_pixel,
  input  logic                  q_full,
  output logic                  q_wr,
  output cmd_t                  q_data
);

  localparam int L = QUOT_BITS;

  logic                  vld    [0:L];
  logic                  isld   [0:L];
  logic                  sat_x  [0:L];
  logic                  sat_y  [0:L];
  logic [REM_BITS-1:0]   rx     [0:L];
  logic [REM_BITS-1:0]   ry     [0:L];
  logic [QUOT_BITS-1:0]  qx     [0:L];
  logic [QUOT_BITS-1:0]  qy     [0:L];
  logic [IN_BITS-1:0]    lcol   [0:L];
  logic [IN_BITS-1:0]    lrow   [0:L];
  logic [PIX_BITS-1:0]   pix    [0:L];

  logic [REM_BITS-1:0]   rx_next [1:L];
  logic [REM_BITS-1:0]   ry_next [1:L];
  logic [QUOT_BITS-1:0]  qx_next [1:L];
  logic [QUOT_BITS-1:0]  qy_next [1:L];

  logic                  adv;
  logic [IN_BITS-1:0]    wm1, hm1;
  logic [REM_BITS-1:0]   dvx, dvy;
  logic                  keep;

  assign wm1 = IN_BITS'(cfg.iw - IN_DIM_BITS'(1));
  assign hm1 = IN_BITS'(cfg.ih - IN_DIM_BITS'(1));
  assign dvx = REM_BITS'(cfg.ow) << IN_BITS;
  assign dvy = REM_BITS'(cfg.oh) << IN_BITS;

  assign adv      = !(vld[L] && q_full);
  assign in_ready = adv;
  assign q_wr     = vld[L] && !q_full;
  assign keep     = (in_op == OP_COMPUTE) ||
                    ((in_col < COORD_BITS'(cfg.iw)) && (in_row < COORD_BITS'(cfg.ih)));

  // One restoring-division step per stage and axis
  always_comb begin
    logic [REM_BITS-1:0] shx, shy;
    logic                gx, gy;
    for (int k = 1; k <= L; k++) begin
      shx = {rx[k-1][REM_BITS-2:0], 1'b0};
      shy = {ry[k-1][REM_BITS-2:0], 1'b0};
      gx  = shx >= dvx;
      gy  = shy >= dvy;
      rx_next[k] = gx ? shx - dvx : shx;
      ry_next[k] = gy ? shy - dvy : shy;
      qx_next[k] = {qx[k-1][QUOT_BITS-2:0], gx};
      qy_next[k] = {qy[k-1][QUOT_BITS-2:0], gy};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= L; k++) vld[k] <= 1'b0;
    end else if (adv) begin
      vld[0] <= in_valid && keep;
      for (int k = 1; k <= L; k++) vld[k] <= vld[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      isld[0]  <= (in_op == OP_LOAD);
      sat_x[0] <= (OUT_DIM_BITS'(in_col) >= cfg.ow) || (wm1 == '0);
      sat_y[0] <= (OUT_DIM_BITS'(in_row) >= cfg.oh) || (hm1 == '0);
      rx[0]    <= REM_BITS'(REM_BITS'(in_col) * REM_BITS'(wm1));
      ry[0]    <= REM_BITS'(REM_BITS'(in_row) * REM_BITS'(hm1));
      qx[0]    <= '0;
      qy[0]    <= '0;
      lcol[0]  <= in_col[IN_BITS-1:0];
      lrow[0]  <= in_row[IN_BITS-1:0];
      pix[0]   <= in_pixel;
      for (int k = 1; k <= L; k++) begin
        isld[k]  <= isld[k-1];
        sat_x[k] <= sat_x[k-1];
        sat_y[k] <= sat_y[k-1];
        rx[k]    <= rx_next[k];
        ry[k]    <= ry_next[k];
        qx[k]    <= qx_next[k];
        qy[k]    <= qy_next[k];
        lcol[k]  <= lcol[k-1];
        lrow[k]  <= lrow[k-1];
        pix[k]   <= pix[k-1];
      end
    end
  end

  // Saturate at the last source index, take neighbours, zero weights for nearest; loads keep their coordinates
  always_comb begin
    logic [IN_BITS-1:0] x1, y1;
    x1 = sat_x[L] ? wm1 : qx[L][QUOT_BITS-1:FRAC_BITS];
    y1 = sat_y[L] ? hm1 : qy[L][QUOT_BITS-1:FRAC_BITS];
    q_data.is_load     = isld[L];
    q_data.alpha_force = cfg.alpha_force;
    q_data.pixel       = pix[L];
    if (isld[L]) begin
      q_data.x1 = lcol[L];
      q_data.x2 = lcol[L];
      q_data.y1 = lrow[L];
      q_data.y2 = lrow[L];
      q_data.fx = '0;
      q_data.fy = '0;
    end else begin
      q_data.x1 = x1;
      q_data.y1 = y1;
      q_data.x2 = sat_x[L] ? x1 : x1 + IN_BITS'(1);
      q_data.y2 = sat_y[L] ? y1 : y1 + IN_BITS'(1);
      q_data.fx = (sat_x[L] || cfg.nearest) ? '0 : qx[L][FRAC_BITS-1:0];
      q_data.fy = (sat_y[L] || cfg.nearest) ? '0 : qy[L][FRAC_BITS-1:0];
    end
  end

endmodule

/* design/bis_queue.sv */
// Short command queue between front and back.
// Uses bis_pkg for the command type and depth.
module bis_queue import bis_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  cmd_t wdata,
  output logic full,
  input  logic rd,
  output logic empty,
  output cmd_t rdata
);

  localparam int PB = $clog2(QUEUE_DEPTH);

  cmd_t          mem [QUEUE_DEPTH];
  logic [PB-1:0] wp, rp;
  logic [PB:0]   count;

  assign full  = (count == (PB+1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp    <= '0;
      rp    <= '0;
      count <= '0;
    end else begin
      if (wr) wp <= wp + PB'(1);
      if (rd) rp <= rp + PB'(1);
      count <= count + (PB+1)'(wr) - (PB+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wp] <= wdata;
  end

endmodule

/* design/bis_back.sv */
// Back end: owns the pixel store, fetches four neighbours per compute,
// blends them and buffers results. Uses bis_pkg and bis_ram.
module bis_back import bis_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_empty,
  input  cmd_t                q_data,
  output logic                q_rd,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PIX_BITS-1:0] out_pixel
);

  localparam int OB = $clog2(OUT_DEPTH);
  localparam int RB = $clog2(OUT_DEPTH + 1);

  bk_state_t            state, state_next;
  cmd_t                 cur;
  logic [RB-1:0]        reserved;
  logic                 start, issue, ram_we;
  logic [1:0]           issue_tag;
  logic [ADDR_BITS-1:0] ram_addr;
  logic [PIX_BITS-1:0]  rdata;

  logic                 rd_vld;
  logic [1:0]           rd_tag;
  logic [PIX_BITS-1:0]  p11, p12;
  logic [TOP_BITS-1:0]  top   [NUM_CHAN];
  logic                 a_vld, a_alpha;
  logic [TOP_BITS-1:0]  a_top [NUM_CHAN];
  logic [TOP_BITS-1:0]  a_bot [NUM_CHAN];
  logic [FRAC_BITS-1:0] a_fy;
  logic                 b_vld, b_alpha;
  logic [ACC_BITS-1:0]  b_pt  [NUM_CHAN];
  logic [ACC_BITS-1:0]  b_pb  [NUM_CHAN];
  logic [PIX_BITS-1:0]  c_pix;

  logic [PIX_BITS-1:0]  ob [OUT_DEPTH];
  logic [OB-1:0]        ob_wp, ob_rp;
  logic [RB-1:0]        ob_cnt;
  logic                 pop;

  bis_ram #(.WIDTH(PIX_BITS), .DEPTH(STORE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (q_data.pixel),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= BK_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    q_rd       = 1'b0;
    ram_we     = 1'b0;
    start      = 1'b0;
    issue      = 1'b0;
    issue_tag  = 2'd0;
    ram_addr   = {q_data.y1, q_data.x1};
    case (state)
      BK_IDLE: begin
        if (!q_empty) begin
          if (q_data.is_load) begin
            ram_we = 1'b1;
            q_rd   = 1'b1;
          end else if (reserved < RB'(OUT_DEPTH)) begin
            q_rd       = 1'b1;
            start      = 1'b1;
            issue      = 1'b1;
            state_next = BK_RD1;
          end
        end
      end
      BK_RD1: begin
        ram_addr   = {cur.y1, cur.x2};
        issue      = 1'b1;
        issue_tag  = 2'd1;
        state_next = BK_RD2;
      end
      BK_RD2: begin
        ram_addr   = {cur.y2, cur.x1};
        issue      = 1'b1;
        issue_tag  = 2'd2;
        state_next = BK_RD3;
      end
      BK_RD3: begin
        ram_addr   = {cur.y2, cur.x2};
        issue      = 1'b1;
        issue_tag  = 2'd3;
        state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (start) cur <= q_data;
  end

  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld   <= 1'b0;
      a_vld    <= 1'b0;
      b_vld    <= 1'b0;
      reserved <= '0;
    end else begin
      rd_vld   <= issue;
      a_vld    <= rd_vld && (rd_tag == 2'd3);
      b_vld    <= a_vld;
      reserved <= reserved + RB'(start) - RB'(pop);
    end
  end

  // Horizontal blend on the second and fourth fetch, vertical products after
  always_ff @(posedge clk) begin
    rd_tag <= issue_tag;
    if (rd_vld && rd_tag == 2'd0) p11 <= rdata;
    if (rd_vld && rd_tag == 2'd2) p12 <= rdata;
    for (int k = 0; k < NUM_CHAN; k++) begin
      if (rd_vld && rd_tag == 2'd1)
        top[k] <= TOP_BITS'(p11[k*CHAN_BITS +: CHAN_BITS])
                  * TOP_BITS'(ONE - WGT_BITS'(cur.fx))
                + TOP_BITS'(rdata[k*CHAN_BITS +: CHAN_BITS]) * TOP_BITS'(cur.fx);
      if (rd_vld && rd_tag == 2'd3) begin
        a_top[k] <= top[k];
        a_bot[k] <= TOP_BITS'(p12[k*CHAN_BITS +: CHAN_BITS])
                    * TOP_BITS'(ONE - WGT_BITS'(cur.fx))
                  + TOP_BITS'(rdata[k*CHAN_BITS +: CHAN_BITS]) * TOP_BITS'(cur.fx);
      end
      b_pt[k] <= ACC_BITS'(a_top[k]) * ACC_BITS'(ONE - WGT_BITS'(a_fy));
      b_pb[k] <= ACC_BITS'(a_bot[k]) * ACC_BITS'(a_fy);
    end
    if (rd_vld && rd_tag == 2'd3) begin
      a_fy    <= cur.fy;
      a_alpha <= cur.alpha_force;
    end
    b_alpha <= a_alpha;
  end

  // Sum, drop fraction, saturate, force alpha to full when set
  always_comb begin
    logic [ACC_BITS-1:0] s;
    logic [ACC_BITS-2*FRAC_BITS-1:0] hi;
    for (int k = 0; k < NUM_CHAN; k++) begin
      s  = b_pt[k] + b_pb[k];
      hi = s[ACC_BITS-1:2*FRAC_BITS];
      c_pix[k*CHAN_BITS +: CHAN_BITS] = (hi > (ACC_BITS-2*FRAC_BITS)'(CHAN_MAX)) ?
                                        CHAN_MAX : hi[CHAN_BITS-1:0];
    end
    if (b_alpha) c_pix[(NUM_CHAN-1)*CHAN_BITS +: CHAN_BITS] = CHAN_MAX;
  end

  assign out_valid = (ob_cnt != '0);
  assign out_pixel = ob[ob_rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      ob_wp  <= '0;
      ob_rp  <= '0;
      ob_cnt <= '0;
    end else begin
      if (b_vld) ob_wp <= ob_wp + OB'(1);
      if (pop)   ob_rp <= ob_rp + OB'(1);
      ob_cnt <= ob_cnt + RB'(b_vld) - RB'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (b_vld) ob[ob_wp] <= c_pix;
  end

endmodule

/* design/bilinear_image_scaler.sv */
// Bilinear image scaler top level: configuration registers, front end,
// command queue and back end. Uses bis_pkg, bis_front, bis_queue, bis_back.
//
// Usage:
//   Input stream (s_*): one transaction per item. tuser is the opcode: load
//   writes one source pixel into the 256x256 pixel store, compute asks for
//   one output pixel at (col,row). Loads outside the set source size drop.
//   Output stream (m_*): one RGBA transaction per compute, in input order.
//   Configuration: cfg_we/cfg_index/cfg_data write the five size and mode
//   registers; write them only while no work is in flight.
// Path: a compute transaction goes through the 25-stage coordinate divider,
//   the queue, four fetches and three blend stages to its result.
// Throughput: a compute holds the back end for its four neighbour reads on
//   the single-port pixel memory before the next command is taken; a load only
//   writes it. The front end takes one item per cycle while the queue has room.
// Reset: rst clears all valid state and the registers to 256x256 -> 256x256
//   bilinear RGBA. The pixel store is not cleared: load it before computing.
// Stall: results wait in a four-entry output buffer; when it is reserved
//   full the back end holds, the queue fills and s_tready drops.
module bilinear_image_scaler import bis_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // col[11:0], row[23:12], red[31:24], green[39:32], blue[47:40], alpha[55:48]
  input  logic [55:0]              s_tdata,
  // opcode[0]
  input  logic [0:0]               s_tuser,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // out_red[7:0], out_green[15:8], out_blue[23:16], out_alpha[31:24]
  output logic [31:0]              m_tdata,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [CFG_IN_BITS-1:0]  in_width, in_height;
  logic [CFG_OUT_BITS-1:0] out_width, out_height;
  logic [1:0]              mode;
  cfg_t                    cfg;
  logic                    q_wr, q_full, q_rd, q_empty;
  cmd_t                    q_wdata, q_rdata;

  // Register writes; unknown index drops
  always_ff @(posedge clk) begin
    if (rst) begin
      in_width   <= CFG_IN_BITS'(256);
      in_height  <= CFG_IN_BITS'(256);
      out_width  <= CFG_OUT_BITS'(256);
      out_height <= CFG_OUT_BITS'(256);
      mode       <= MODE_RGBA;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IN_WIDTH:   in_width   <= cfg_data[CFG_IN_BITS-1:0];
        REG_IN_HEIGHT:  in_height  <= cfg_data[CFG_IN_BITS-1:0];
        REG_OUT_WIDTH:  out_width  <= cfg_data[CFG_OUT_BITS-1:0];
        REG_OUT_HEIGHT: out_height <= cfg_data[CFG_OUT_BITS-1:0];
        REG_MODE:       mode       <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Zero sizes act as one, oversize clamps; modes 2 and 3 are nearest
  assign cfg.iw          = clamp_in(in_width);
  assign cfg.ih          = clamp_in(in_height);
  assign cfg.ow          = clamp_out(out_width);
  assign cfg.oh          = clamp_out(out_height);
  assign cfg.nearest     = mode[1];
  assign cfg.alpha_force = (mode != MODE_RGBA);

  bis_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .in_op    (s_tuser[0]),
    .in_col   (s_tdata[11:0]),
    .in_row   (s_tdata[23:12]),
    .in_pixel (s_tdata[55:24]),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_data   (q_wdata)
  );

  bis_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .full  (q_full),
    .rd    (q_rd),
    .empty (q_empty),
    .rdata (q_rdata)
  );

  bis_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_data    (q_rdata),
    .q_rd      (q_rd),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pixel (m_tdata)
  );

endmodule

/* design/bis_checker.sv */
// Port-level checker for the bilinear image scaler, bound to the top level.
// Uses bis_pkg and the macros of bilinear_image_scaler_assert.svh.
`include "bilinear_image_scaler_assert.svh"
module bis_checker import bis_pkg::*; (
  input logic                     clk,
  input logic                     rst,
  input logic                     s_tvalid,
  input logic                     s_tready,
  input logic [55:0]              s_tdata,
  input logic [0:0]               s_tuser,
  input logic                     m_tvalid,
  input logic                     m_tready,
  input logic [31:0]              m_tdata,
  input logic                     cfg_we,
  input logic [CFG_IDX_BITS-1:0]  cfg_index,
  input logic [CFG_DATA_BITS-1:0] cfg_data
);

  logic [15:0] pend;
  logic        in_cmp, out_acc;

  assign in_cmp  = s_tvalid && s_tready && (s_tuser[0] == OP_COMPUTE);
  assign out_acc = m_tvalid && m_tready;

  // Count computes whose results are not yet taken
  always_ff @(posedge clk) begin
    if (rst) pend <= '0;
    else     pend <= pend + 16'(in_cmp) - 16'(out_acc);
  end

  `BIS_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "output changed while stalled")
  `BIS_ASSERT_ALWAYS(a_rst_clear, rst, !m_tvalid, "output valid right after reset")
  `BIS_ASSERT_SAME(a_no_phantom, m_tvalid, pend != 16'd0, "result without a pending compute")

endmodule

bind bilinear_image_scaler bis_checker u_chk (.*);
